// ===== src/assert_macros.svh =====
// Assertion macros shared by the finder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge out of reset
`define CSF_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("csf assertion failed");

// Check that a consequent follows an antecedent in the same cycle
`define CSF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("csf assertion failed");

// Check that a consequent follows an antecedent in the next cycle
`define CSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("csf assertion failed");

`endif

// ===== src/csf_pkg.sv =====
// Package with types, constants and helpers of the case-folded substring finder
`timescale 1ns / 1ps

package csf_pkg;

    localparam int MAX_QUERY_UNITS = 16;
    localparam int UNIT_W          = 16;
    localparam int LEN_W           = $clog2(MAX_QUERY_UNITS + 1);
    localparam int QIDX_W          = $clog2(MAX_QUERY_UNITS);
    localparam int POS_W           = 16;
    localparam int FRAG_W          = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int UNITS_PER_WORD  = CFG_DATA_W / UNIT_W;
    localparam int UNIT_SEL_W      = $clog2(UNITS_PER_WORD);
    localparam int WORD_SEL_W      = QIDX_W - UNIT_SEL_W;

    localparam logic [UNIT_W-1:0] CHAR_UPPER_A = 16'h0041;
    localparam logic [UNIT_W-1:0] CHAR_UPPER_Z = 16'h005A;
    localparam logic [UNIT_W-1:0] CHAR_LOWER_A = 16'h0061;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_0_3    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_4_7    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_8_11   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_12_15  = 3'd4;

    typedef logic [UNIT_W-1:0] unit_t;
    typedef unit_t [MAX_QUERY_UNITS-1:0] units_t;

    typedef struct packed {
        logic [LEN_W-1:0]  match_length;
        logic [POS_W-1:0]  match_start;
        logic [FRAG_W-1:0] match_fragment;
    } result_t;

    function automatic unit_t fold_unit(input unit_t c);
        unit_t r;
        r = c;
        if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            r = c - CHAR_UPPER_A + CHAR_LOWER_A;
        end
        return r;
    endfunction

endpackage

// ===== src/csf_match.sv =====
// Parallel end-aligned compare of the text window against the query
`timescale 1ns / 1ps

module csf_match (
    input  csf_pkg::units_t                window,
    input  csf_pkg::units_t                query,
    input  logic [csf_pkg::LEN_W-1:0]      len,
    input  logic [csf_pkg::LEN_W-1:0]      fill,
    output logic                           hit
);
    import csf_pkg::*;

    logic [MAX_QUERY_UNITS-1:0] lane_ok;
    logic [LEN_W-1:0]           qsel [MAX_QUERY_UNITS];

    always_comb begin
        for (int j = 0; j < MAX_QUERY_UNITS; j++) begin
            qsel[j]    = len - LEN_W'(1) - LEN_W'(j);
            lane_ok[j] = (LEN_W'(j) >= len) ||
                         (window[j] == query[qsel[j][QIDX_W-1:0]]);
        end
        hit = (len != '0) && (fill >= len) && (&lane_ok);
    end

endmodule

// ===== src/case_folded_substring_finder_top.sv =====
// Top level of the case-folded substring finder
//
//  channel | direction | tdata (low bit up)                         | tuser
//  s_      | in        | code_unit, fragment_number                 | starts_fragment
//  m_      | out       | match_fragment, match_start, match_length  | -
//  cfg_    | in        | write enable, register index, 64-bit data  | -
//
// One item per cycle while s_tready is high.
// The result register plus one skid entry let items flow while m_tready is low;
// s_tready drops only when the skid entry is full.
// Reset is synchronous on aresetn and clears all state but the result and skid data;
// no clearing pass. Results are registered from the item that ends the match.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module case_folded_substring_finder_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // code_unit, fragment_number
    input  logic                              s_tuser,  // starts_fragment
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,  // match_fragment, match_start,
                                                        // match_length, zero pad
    input  logic                              cfg_wr_en,
    input  logic [csf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import csf_pkg::*;

    logic [LEN_W-1:0]  query_length_reg;
    units_t            query_reg;
    units_t            window_reg;
    logic [LEN_W-1:0]  fill_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              past_end_reg;
    logic [LEN_W-1:0]  supp_reg;
    logic [FRAG_W-1:0] frag_reg;
    result_t           out_reg;
    logic              out_valid_reg;
    result_t           skid_reg;
    logic              skid_valid_reg;

    logic              accept;
    logic              pop;
    unit_t             unit_fold;
    logic              start;
    logic [LEN_W-1:0]  len_eff;
    logic [FRAG_W-1:0] frag_cur;
    logic [LEN_W-1:0]  fill_cur;
    logic [POS_W-1:0]  pos_cur;
    logic              past_cur;
    logic [LEN_W-1:0]  supp_cur;
    units_t            window_next;
    logic [LEN_W-1:0]  fill_next;
    logic [POS_W-1:0]  pos_next;
    logic              past_end_next;
    logic [LEN_W-1:0]  supp_next;
    logic              hit;
    logic              report;
    result_t           res;
    logic [WORD_SEL_W-1:0] cfg_word;

    assign accept    = s_tvalid && s_tready;
    assign pop       = out_valid_reg && m_tready;
    assign s_tready  = !skid_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_reg};

    assign unit_fold = fold_unit(s_tdata[UNIT_W-1:0]);
    assign start     = s_tuser;
    assign len_eff   = (query_length_reg > LEN_W'(MAX_QUERY_UNITS)) ?
                       LEN_W'(MAX_QUERY_UNITS) : query_length_reg;
    assign cfg_word  = WORD_SEL_W'(cfg_index - REG_QUERY_0_3);

    // Restart the fragment context on a start flag
    always_comb begin
        frag_cur = start ? s_tdata[2*UNIT_W-1:UNIT_W] : frag_reg;
        fill_cur = start ? '0 : fill_reg;
        pos_cur  = start ? '0 : pos_reg;
        past_cur = start ? 1'b0 : past_end_reg;
        supp_cur = start ? '0 : supp_reg;
    end

    always_comb begin
        window_next   = {window_reg[MAX_QUERY_UNITS-2:0], unit_fold};
        fill_next     = (fill_cur < LEN_W'(MAX_QUERY_UNITS)) ? fill_cur + LEN_W'(1) : fill_cur;
        past_end_next = past_cur || (pos_cur == {POS_W{1'b1}});
        pos_next      = (pos_cur == {POS_W{1'b1}}) ? pos_cur : pos_cur + POS_W'(1);
    end

    csf_match u_match (
        .window (window_next),
        .query  (query_reg),
        .len    (len_eff),
        .fill   (fill_next),
        .hit    (hit)
    );

    always_comb begin
        report             = hit && (supp_cur == '0) && !past_cur;
        res.match_fragment = frag_cur;
        res.match_start    = pos_cur + POS_W'(1) - POS_W'(len_eff);
        res.match_length   = len_eff;
        if (report) begin
            supp_next = len_eff - LEN_W'(1);
        end else if (supp_cur != '0) begin
            supp_next = supp_cur - LEN_W'(1);
        end else begin
            supp_next = supp_cur;
        end
    end

    // Configuration registers; fold query units as they are written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_length_reg <= '0;
            query_reg        <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_QUERY_LENGTH: query_length_reg <= cfg_wdata[LEN_W-1:0];
                REG_QUERY_0_3, REG_QUERY_4_7, REG_QUERY_8_11, REG_QUERY_12_15: begin
                    for (int k = 0; k < UNITS_PER_WORD; k++) begin
                        query_reg[{cfg_word, UNIT_SEL_W'(k)}] <=
                            fold_unit(cfg_wdata[k*UNIT_W +: UNIT_W]);
                    end
                end
                default: ;
            endcase
        end
    end

    // Stream state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= '0;
            fill_reg     <= '0;
            pos_reg      <= '0;
            past_end_reg <= 1'b0;
            supp_reg     <= '0;
            frag_reg     <= '0;
        end else if (accept) begin
            window_reg   <= window_next;
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            past_end_reg <= past_end_next;
            supp_reg     <= supp_next;
            frag_reg     <= frag_cur;
        end
    end

    // Result register and skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || pop) begin
            out_valid_reg <= accept && report;
        end else if (accept && report) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (!out_valid_reg || pop) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || pop) begin
            out_reg <= res;
        end else if (accept && report) begin
            skid_reg <= res;
        end
    end

    `CSF_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `CSF_ASSERT_IMPL(a_out_len_range, out_valid_reg, (out_reg.match_length != '0) && (out_reg.match_length <= LEN_W'(MAX_QUERY_UNITS)))
    `CSF_ASSERT(a_supp_below_len, supp_reg < LEN_W'(MAX_QUERY_UNITS))
    `CSF_ASSERT(a_fill_range, fill_reg <= LEN_W'(MAX_QUERY_UNITS))
    `CSF_ASSERT_NEXT(a_start_resets_pos, accept && s_tuser, pos_reg == POS_W'(1))

endmodule

// ===== verif/tb_top.sv =====
// Self-checking stream testbench for the case-folded substring finder top level
`timescale 1ns / 1ps

module tb_top;
    import csf_pkg::*;

    localparam int FRAG_CHAR_LIMIT = 65536;
    localparam int LONG_FRAG_UNITS = 290;
    localparam int DRAIN_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [POS_W-1:0]  start;
        logic [FRAG_W-1:0] frag;
    } match_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;  // code_unit, fragment_number
    logic                  s_tuser   = 1'b0; // starts_fragment
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;          // match_fragment, match_start, match_length
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     mismatch_count = 0;
    match_t pending_matches[$];

    logic [LEN_W-1:0]  query_len_reg = '0;
    units_t            query_reg     = '0;
    unit_t             fold_win [MAX_QUERY_UNITS];
    int                win_fill      = 0;
    int                next_pos      = 0;
    bit                pos_saturated = 1'b0;
    int                hold_off      = 0;
    logic [FRAG_W-1:0] frag_latch    = '0;

    case_folded_substring_finder_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb_top: errors");
        $finish;
    end

    function automatic unit_t to_lower(input unit_t u);
        if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z) begin
            return u - CHAR_UPPER_A + CHAR_LOWER_A;
        end
        return u;
    endfunction

    function automatic unit_t flip_case(input unit_t u);
        unit_t lo;
        lo = to_lower(u);
        if (lo != u || (lo >= CHAR_LOWER_A && lo < CHAR_LOWER_A + 26)) begin
            return $urandom_range(1) ? lo - CHAR_LOWER_A + CHAR_UPPER_A : lo;
        end
        return u;
    endfunction

    function automatic unit_t random_unit();
        if ($urandom_range(9) == 0) begin
            return unit_t'($urandom_range(65535));
        end
        return flip_case(CHAR_LOWER_A + unit_t'($urandom_range(1)));
    endfunction

    function automatic units_t units_of(input string txt);
        units_t u;
        u = '0;
        for (int i = 0; i < txt.len() && i < MAX_QUERY_UNITS; i++) begin
            u[i] = unit_t'(txt[i]);
        end
        return u;
    endfunction

    // advance the finder by one code unit and queue the match it ends, if any
    function automatic void advance_finder(input unit_t cu, input logic [FRAG_W-1:0] frag,
                                           input logic first);
        int     len;
        int     this_pos;
        bit     in_range;
        bit     hit;
        match_t m;
        len = (query_len_reg > MAX_QUERY_UNITS) ? MAX_QUERY_UNITS : int'(query_len_reg);
        if (first) begin
            frag_latch    = frag;
            win_fill      = 0;
            next_pos      = 0;
            pos_saturated = 1'b0;
            hold_off      = 0;
        end
        this_pos = next_pos;
        in_range = !pos_saturated;
        if (next_pos >= FRAG_CHAR_LIMIT - 1) begin
            pos_saturated = 1'b1;
        end else begin
            next_pos++;
        end
        for (int i = MAX_QUERY_UNITS - 1; i > 0; i--) begin
            fold_win[i] = fold_win[i-1];
        end
        fold_win[0] = to_lower(cu);
        if (win_fill < MAX_QUERY_UNITS) begin
            win_fill++;
        end
        hit = (len > 0) && (win_fill >= len);
        for (int i = 0; i < len; i++) begin
            if (fold_win[len-1-i] != to_lower(query_reg[i])) begin
                hit = 1'b0;
            end
        end
        if (hit && hold_off == 0 && in_range) begin
            m.frag  = frag_latch;
            m.start = POS_W'(this_pos + 1 - len);
            m.len   = LEN_W'(len);
            pending_matches.insert(pending_matches.size(), m);
            hold_off = len - 1;
        end else if (hold_off > 0) begin
            hold_off--;
        end
    endfunction

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic send_unit(input unit_t cu, input logic [FRAG_W-1:0] frag,
                             input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {frag, cu};
        s_tuser  <= first;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        advance_finder(cu, frag, first);
    endtask

    task automatic send_text(input string txt, input logic [FRAG_W-1:0] frag,
                             input logic first);
        for (int i = 0; i < txt.len(); i++) begin
            send_unit(unit_t'(txt[i]), frag, first && i == 0);
        end
    endtask

    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_query(input logic [LEN_W-1:0] len, input units_t q);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_QUERY_LENGTH;
        cfg_wdata <= CFG_DATA_W'(len);
        @(posedge aclk);
        query_len_reg = len;
        for (int w = 0; w < 4; w++) begin
            cfg_index <= REG_QUERY_0_3 + CFG_IDX_W'(w);
            cfg_wdata <= q[w*UNITS_PER_WORD +: UNITS_PER_WORD];
            @(posedge aclk);
            query_reg[w*UNITS_PER_WORD +: UNITS_PER_WORD] = q[w*UNITS_PER_WORD +: UNITS_PER_WORD];
        end
        cfg_wr_en <= 1'b0;
    endtask

    always @(posedge aclk) begin : result_monitor
        match_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_matches.size() == 0) begin
                $display("%0t: unexpected match, expected none, got %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_matches.pop_front();
                if (m_tdata[15:0] != want.frag || m_tdata[31:16] != want.start ||
                    m_tdata[36:32] != want.len || m_tdata[39:37] != '0) begin
                    $display("%0t: match mismatch, expected frag %h start %h len %0d, got %h",
                             $time, want.frag, want.start, want.len, m_tdata);
                    mismatch_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic test_unflagged_start();
        load_query(LEN_W'(2), units_of("aB"));
        send_text("xAb", 16'h1234, 1'b0);
        wait_for_idle();
    endtask

    task automatic test_case_folding();
        load_query(LEN_W'(4), units_of("Az@["));
        send_text("AZ@[az`{", 16'hFFFF, 1'b1);
        wait_for_idle();
    endtask

    task automatic test_overlap_and_tag_change();
        load_query(LEN_W'(2), units_of("aa"));
        send_text("aaa", 16'd5, 1'b1);
        send_text("a", 16'd9, 1'b0);
        wait_for_idle();
    endtask

    task automatic test_query_change_midstream();
        load_query(LEN_W'(3), units_of("abc"));
        send_text("abc", 16'd7, 1'b1);
        wait_for_idle();
        load_query(LEN_W'(1), units_of("C"));
        send_text("ccc", 16'h8000, 1'b0);
        wait_for_idle();
    endtask

    task automatic test_empty_and_overlong_query();
        units_t q;
        load_query(LEN_W'(0), units_of("a"));
        send_text("aa", 16'd3, 1'b1);
        wait_for_idle();
        q    = units_of("xxAbCdEfGhIjKlMn");
        q[0] = 16'hFFFF;
        q[1] = 16'h0000;
        load_query(LEN_W'(31), q);
        for (int k = 0; k < MAX_QUERY_UNITS; k++) begin
            send_unit(flip_case(q[k]), 16'h0000, k == 0);
        end
        wait_for_idle();
    endtask

    task automatic test_random_text();
        units_t            q;
        int                qlen;
        int                eff;
        int                sel;
        bit                rand_words;
        logic              first;
        logic [FRAG_W-1:0] frag;
        for (int phase = 0; phase < 21; phase++) begin
            if (phase == 7) begin
                set_idling(48, 16);
            end else if (phase == 14) begin
                set_idling(0, 0);
            end
            sel = $urandom_range(99);
            if (sel < 5) begin
                qlen = 0;
            end else if (sel < 10) begin
                qlen = MAX_QUERY_UNITS;
            end else if (sel < 15) begin
                qlen = $urandom_range(31, 17);
            end else begin
                qlen = $urandom_range(5, 1);
            end
            eff = (qlen > MAX_QUERY_UNITS) ? MAX_QUERY_UNITS : qlen;
            rand_words = ($urandom_range(3) == 0);
            for (int k = 0; k < MAX_QUERY_UNITS; k++) begin
                q[k] = rand_words ? unit_t'($urandom_range(65535)) : random_unit();
            end
            wait_for_idle();
            load_query(LEN_W'(qlen), q);
            for (int n = 0; n < 24; n++) begin
                sel   = $urandom_range(99);
                first = (n == 0 && $urandom_range(1) == 1) || $urandom_range(99) < 5;
                frag  = FRAG_W'($urandom);
                if (sel < 25 && eff > 0) begin
                    for (int k = 0; k < eff; k++) begin
                        send_unit(flip_case(q[k]), frag, first && k == 0);
                    end
                end else if (sel < 35) begin
                    send_unit(unit_t'($urandom_range(65535)), frag, first);
                end else begin
                    send_unit(random_unit(), frag, first);
                end
            end
        end
        wait_for_idle();
    endtask

    task automatic test_long_fragment();
        load_query(LEN_W'(2), units_of("ab"));
        send_unit(unit_t'("x"), 16'hABCD, 1'b1);
        for (int i = 1; i < LONG_FRAG_UNITS; i++) begin
            send_unit(unit_t'("x"), 16'hABCD, 1'b0);
        end
        send_text("abababAB", 16'hABCD, 1'b0);
        send_text("ab", 16'h0001, 1'b1);
        wait_for_idle();
    endtask

    initial begin
        for (int i = 0; i < MAX_QUERY_UNITS; i++) begin
            fold_win[i] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_idling(16, 48);
        test_unflagged_start();
        test_case_folding();
        test_overlap_and_tag_change();
        test_query_change_midstream();
        test_empty_and_overlong_query();
        test_random_text();
        test_long_fragment();
        wait_for_idle();
        if (mismatch_count == 0 && pending_matches.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/csf_pkg.sv
src/csf_match.sv
src/case_folded_substring_finder_top.sv
verif/tb_top.sv
